### hw/rtl/chks_pkg.sv
// Shared types, constants and bucket hash for the chained hash key set.
package chks_pkg;

  localparam int unsigned TableSize = 128;
  localparam int unsigned KeyW      = 32;
  localparam int unsigned IdxW      = $clog2(TableSize);
  localparam int unsigned CntW      = IdxW + 1;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_MISSING  = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  localparam logic CMD_ADD = 1'b1;

  typedef struct packed {
    logic            cmd;
    logic [KeyW-1:0] key;
  } req_t;

  typedef struct packed {
    status_e         status;
    logic [IdxW-1:0] index;
    logic [CntW-1:0] key_count;
  } res_t;

  // chain link: valid flag and index of the next entry
  typedef struct packed {
    logic            vld;
    logic [IdxW-1:0] idx;
  } link_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic step_head;
    logic step_next;
    logic finish;
    logic found;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic head_ok;
    logic hit;
    logic next_ok;
  } sts_t;

  // XOR-fold to 16 bits, then modulo the table size
  function automatic logic [IdxW-1:0] bucket_of(input logic [KeyW-1:0] k);
    logic [15:0] f;
    f = k[31:16] ^ k[15:0];
    return f[IdxW-1:0];
  endfunction

endpackage

### hw/rtl/chks_ctrl.sv
// Request sequencer for the chained hash key set.
module chks_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  chks_pkg::sts_t sts_i,
  output chks_pkg::ctl_t ctl_o,
  output logic          busy_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_HEAD = 3'b010,
    S_WALK = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_HEAD;
        end
      end
      S_HEAD: begin
        if (sts_i.head_ok) begin
          ctl_o.step_head = 1'b1;
          state_d         = S_WALK;
        end else begin
          ctl_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_WALK: begin
        if (sts_i.hit) begin
          ctl_o.finish = 1'b1;
          ctl_o.found  = 1'b1;
          state_d      = S_IDLE;
        end else if (sts_i.next_ok) begin
          ctl_o.step_next = 1'b1;
        end else begin
          ctl_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

### hw/rtl/chks_dp.sv
// Datapath of the chained hash key set: key, link and bucket memories.
module chks_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  chks_pkg::req_t req_i,
  input  chks_pkg::ctl_t ctl_i,
  output chks_pkg::sts_t sts_o,
  output chks_pkg::res_t res_o,
  output logic           done_o
);

  localparam int unsigned TableSize = chks_pkg::TableSize;
  localparam int unsigned KeyW      = chks_pkg::KeyW;
  localparam int unsigned IdxW      = chks_pkg::IdxW;
  localparam int unsigned CntW      = chks_pkg::CntW;

  logic [KeyW-1:0]      key_mem  [TableSize];
  chks_pkg::link_t      next_mem [TableSize];
  logic [IdxW-1:0]      head_mem [TableSize];
  logic [TableSize-1:0] head_vld_q;

  logic [KeyW-1:0]  key_q;
  logic             cmd_q;
  logic [IdxW-1:0]  bucket_q;
  logic [IdxW-1:0]  cur_q;
  logic [CntW-1:0]  count_q;
  logic [IdxW-1:0]  head_rd_q;
  logic [KeyW-1:0]  key_rd_q;
  chks_pkg::link_t  next_rd_q;
  chks_pkg::res_t   res_q;
  logic             done_q;

  logic             head_vld;
  logic             full;
  logic             do_insert;
  logic             rd_en;
  logic [IdxW-1:0]  rd_addr;
  logic [IdxW-1:0]  wr_idx;

  assign head_vld = head_vld_q[bucket_q];
  assign full     = (count_q == CntW'(TableSize));
  assign wr_idx   = count_q[IdxW-1:0];

  assign sts_o.head_ok = head_vld && ({1'b0, head_rd_q} < count_q);
  assign sts_o.hit     = (key_rd_q == key_q);
  assign sts_o.next_ok = next_rd_q.vld && ({1'b0, next_rd_q.idx} < count_q);

  assign rd_en   = ctl_i.step_head | ctl_i.step_next;
  assign rd_addr = ctl_i.step_head ? head_rd_q : next_rd_q.idx;

  assign do_insert = ctl_i.finish && !ctl_i.found && (cmd_q == chks_pkg::CMD_ADD) && !full;

  // request capture
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      key_q    <= req_i.key;
      cmd_q    <= req_i.cmd;
      bucket_q <= chks_pkg::bucket_of(req_i.key);
    end
    if (rd_en) begin
      cur_q <= rd_addr;
    end
  end

  // bucket head memory
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      head_rd_q <= head_mem[chks_pkg::bucket_of(req_i.key)];
    end
    if (do_insert) begin
      head_mem[bucket_q] <= wr_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= '0;
    end else if (do_insert) begin
      head_vld_q[bucket_q] <= 1'b1;
    end
  end

  // key and link memories
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      key_rd_q  <= key_mem[rd_addr];
      next_rd_q <= next_mem[rd_addr];
    end
    if (do_insert) begin
      key_mem[wr_idx]      <= key_q;
      next_mem[wr_idx].vld <= head_vld;
      next_mem[wr_idx].idx <= head_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= ctl_i.finish;
      if (do_insert) begin
        count_q <= count_q + CntW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (ctl_i.finish) begin
      res_q.key_count <= do_insert ? count_q + CntW'(1) : count_q;
      if (ctl_i.found) begin
        res_q.status <= chks_pkg::ST_FOUND;
        res_q.index  <= cur_q;
      end else if (cmd_q != chks_pkg::CMD_ADD) begin
        res_q.status <= chks_pkg::ST_MISSING;
        res_q.index  <= '0;
      end else if (full) begin
        res_q.status <= chks_pkg::ST_FULL;
        res_q.index  <= '0;
      end else begin
        res_q.status <= chks_pkg::ST_INSERTED;
        res_q.index  <= wr_idx;
      end
    end
  end

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

### hw/rtl/chained_hash_key_set_core.sv
// Top level of the chained hash key set: sequencer plus datapath.
//
// A request (find or add of one 32-bit key) is transferred at the clock edge
// where start is high and busy is low. The key's bucket (low 7 bits of the
// 16-bit XOR-fold) is read from the bucket head memory, then the chain is
// walked one link per cycle through the key and link memories. Busy stays high
// through the head read and the walk of the chain entries visited; the result
// appears on res_o with done_o high for exactly one cycle right after, and
// in that same cycle the next request may already be transferred. The chain
// walk, bounded by the single read port of the key/link memory, sets the
// request rate. The receiver cannot stall: each result must be taken in the
// cycle done_o is high. Keys are numbered in insertion order from 0; an add
// of a new key to a full table of 128 keys returns status full. Bucket heads
// are empty after reset with no clearing pass.
module chained_hash_key_set_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  chks_pkg::req_t req_i,
  output chks_pkg::res_t res_o,
  output logic           done_o
);

  chks_pkg::ctl_t ctl;
  chks_pkg::sts_t sts;
  logic           busy_int;

  // sequencer: idle -> read bucket head -> walk chain -> commit
  chks_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .ctl_o  (ctl),
    .busy_o (busy_int)
  );

  // memories, compare and result register
  chks_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .ctl_i  (ctl),
    .sts_o  (sts),
    .res_o  (res_o),
    .done_o (done_o)
  );

  assign busy = busy_int;

endmodule

### dv/testbench.sv
// Self-checking testbench for chained_hash_key_set_core: directed table, then random requests.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned TableSize = chks_pkg::TableSize;
  localparam int unsigned KeyW      = chks_pkg::KeyW;
  localparam int unsigned IdxW      = chks_pkg::IdxW;
  localparam int unsigned CntW      = chks_pkg::CntW;

  // A find is any request that is not an add
  localparam logic        CMD_FIND    = ~chks_pkg::CMD_ADD;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // Longest walk is a full chain plus head read and result cycle
  localparam int unsigned SETTLE_CYCLES = 2 * TableSize + 4;
  localparam logic [IdxW-1:0] HOT_BUCKET_A = 7'h13;
  localparam logic [IdxW-1:0] HOT_BUCKET_B = 7'h6C;

  typedef struct {
    chks_pkg::req_t req;
    bit             pin;     // expected result typed into the row
    chks_pkg::res_t res;
  } stim_row_t;

  typedef struct {
    bit             on;
    chks_pkg::res_t res;
  } pin_t;

  logic           clk_i;
  logic           rst_ni;
  logic           start;
  logic           busy;
  chks_pkg::req_t req_i;
  chks_pkg::res_t res_o;
  logic           done_o;

  // Model of the key set
  logic [KeyW-1:0] key_mem [TableSize] = '{default: '0};
  chks_pkg::link_t next_mem[TableSize] = '{default: '0};
  chks_pkg::link_t head_mem[TableSize] = '{default: '0};
  int unsigned     n_keys = 0;

  chks_pkg::res_t owed_results[$];
  pin_t           typed_results[$];
  int unsigned    errors = 0;
  int unsigned    cycles = 0;
  int unsigned    transfers = 0;
  int unsigned    seen_status[4] = '{default: 0};

  chained_hash_key_set_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .res_o  (res_o),
    .done_o (done_o)
  );

  always #4 clk_i = ~clk_i;

  // XOR-fold of the key into 16 bits, reduced to a bucket number
  function automatic logic [IdxW-1:0] key_bucket(input logic [KeyW-1:0] k);
    logic [15:0] folded;
    folded = k[31:16] ^ k[15:0];
    return IdxW'(folded % TableSize);
  endfunction

  // Chain walk, bounded by the number of stored keys
  function automatic bit locate_key(input logic [KeyW-1:0] k, output int unsigned pos);
    chks_pkg::link_t cur;
    int unsigned     steps;
    cur   = head_mem[key_bucket(k)];
    steps = 0;
    pos   = 0;
    while (cur.vld && steps < n_keys) begin
      if (cur.idx >= n_keys) return 1'b0;
      if (key_mem[cur.idx] == k) begin
        pos = cur.idx;
        return 1'b1;
      end
      cur = next_mem[cur.idx];
      steps++;
    end
    return 1'b0;
  endfunction

  // Applies one request to the model; returns the result it owes
  function automatic chks_pkg::res_t key_set_update(input chks_pkg::req_t r);
    chks_pkg::res_t  o;
    int unsigned     pos;
    logic [IdxW-1:0] b;
    o.index = '0;
    if (locate_key(r.key, pos)) begin
      o.status = chks_pkg::ST_FOUND;
      o.index  = IdxW'(pos);
    end else if (r.cmd != chks_pkg::CMD_ADD) begin
      o.status = chks_pkg::ST_MISSING;
    end else if (n_keys >= TableSize) begin
      o.status = chks_pkg::ST_FULL;
    end else begin
      b                = key_bucket(r.key);
      key_mem[n_keys]  = r.key;
      next_mem[n_keys] = head_mem[b];
      head_mem[b]      = '{vld: 1'b1, idx: IdxW'(n_keys)};
      o.status         = chks_pkg::ST_INSERTED;
      o.index          = IdxW'(n_keys);
      n_keys++;
    end
    o.key_count = CntW'(n_keys);
    return o;
  endfunction

  function automatic stim_row_t pinned(input logic cmd, input logic [KeyW-1:0] key,
                                       input chks_pkg::status_e st, input int unsigned idx,
                                       input int unsigned cnt);
    stim_row_t row;
    row.req = '{cmd: cmd, key: key};
    row.pin = 1'b1;
    row.res = '{status: st, index: IdxW'(idx), key_count: CntW'(cnt)};
    return row;
  endfunction

  function automatic stim_row_t loose(input logic cmd, input logic [KeyW-1:0] key);
    stim_row_t row;
    row.req = '{cmd: cmd, key: key};
    row.pin = 1'b0;
    row.res = '{status: chks_pkg::ST_FOUND, index: '0, key_count: '0};
    return row;
  endfunction

  // Random request: mostly stored keys and keys crowding two hot buckets
  function automatic chks_pkg::req_t random_request(input int unsigned add_pct);
    chks_pkg::req_t  r;
    int unsigned     sel;
    logic [15:0]     hi;
    logic [15:0]     fold;
    logic [IdxW-1:0] hot;
    sel = $urandom_range(0, 99);
    if (sel < 45 && n_keys > 0) begin
      r.key = key_mem[$urandom_range(0, n_keys - 1)];
    end else if (sel < 75) begin
      hot   = ($urandom & 1) ? HOT_BUCKET_A : HOT_BUCKET_B;
      fold  = {9'($urandom), hot};
      hi    = 16'($urandom);
      r.key = {hi, hi ^ fold};
    end else begin
      r.key = $urandom;
    end
    r.cmd = ($urandom_range(0, 99) < add_pct) ? chks_pkg::CMD_ADD : CMD_FIND;
    return r;
  endfunction

  // One transfer; afterwards the sender may idle, with a per-cycle chance
  task automatic issue(input chks_pkg::req_t r, input int unsigned idle_pct);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      req_i <= '{cmd: 1'($urandom), key: $urandom};   // junk while idle must be ignored
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  task automatic drain_results;
    start <= 1'b0;
    do @(posedge clk_i); while (owed_results.size() != 0);
  endtask

  // Sampling at the edge sees the values of the cycle that ends there
  always @(posedge clk_i) begin : watch
    chks_pkg::res_t want;
    pin_t           p;
    if (rst_ni) begin
      if (done_o) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result: status %0d index %0d key_count %0d",
                 res_o.status, res_o.index, res_o.key_count);
          errors++;
        end else begin
          want = owed_results.pop_front();
          if (res_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_o.status);
            errors++;
          end
          if (res_o.index !== want.index) begin
            $error("index: expected %0d, got %0d", want.index, res_o.index);
            errors++;
          end
          if (res_o.key_count !== want.key_count) begin
            $error("key_count: expected %0d, got %0d", want.key_count, res_o.key_count);
            errors++;
          end
        end
        if (!$isunknown(res_o.status)) seen_status[res_o.status]++;
      end
      if (start && !busy) begin
        want = key_set_update(req_i);
        if (typed_results.size() != 0) begin
          p = typed_results.pop_front();
          if (p.on) want = p.res;
        end
        owed_results.push_back(want);
        transfers++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    stim_row_t       dir_rows[$];
    logic [KeyW-1:0] r1;
    logic [KeyW-1:0] r2;
    logic [KeyW-1:0] fresh;
    logic [KeyW-1:0] chosen[$];
    int unsigned     top_up;
    int unsigned     pos;
    bit              clash;

    clk_i  = 1'b0;
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;

    r1 = $urandom;
    r2 = $urandom;
    // Empty table, repeats, extreme keys, a chain in bucket 0 grown to five keys
    // (walked to its tail and past it), two keys in bucket 127
    dir_rows.push_back(pinned(CMD_FIND, 32'h0000_0000, chks_pkg::ST_MISSING,  0, 0));
    dir_rows.push_back(pinned(chks_pkg::CMD_ADD, 32'h0000_0000, chks_pkg::ST_INSERTED, 0, 1));
    dir_rows.push_back(pinned(chks_pkg::CMD_ADD, 32'h0000_0000, chks_pkg::ST_FOUND,    0, 1));
    dir_rows.push_back(pinned(CMD_FIND, 32'h0000_0000, chks_pkg::ST_FOUND,    0, 1));
    dir_rows.push_back(pinned(chks_pkg::CMD_ADD, 32'hFFFF_FFFF, chks_pkg::ST_INSERTED, 1, 2));
    dir_rows.push_back(pinned(CMD_FIND, 32'hFFFF_FFFF, chks_pkg::ST_FOUND,    1, 2));
    dir_rows.push_back(pinned(chks_pkg::CMD_ADD, 32'h0000_0080, chks_pkg::ST_INSERTED, 2, 3));
    dir_rows.push_back(pinned(chks_pkg::CMD_ADD, 32'h0001_0001, chks_pkg::ST_INSERTED, 3, 4));
    dir_rows.push_back(pinned(CMD_FIND, 32'h0000_0000, chks_pkg::ST_FOUND,    0, 4));
    dir_rows.push_back(pinned(CMD_FIND, 32'h0000_0100, chks_pkg::ST_MISSING,  0, 4));
    dir_rows.push_back(pinned(chks_pkg::CMD_ADD, 32'hFFFF_0000, chks_pkg::ST_INSERTED, 4, 5));
    dir_rows.push_back(pinned(chks_pkg::CMD_ADD, 32'h0000_FFFF, chks_pkg::ST_INSERTED, 5, 6));
    dir_rows.push_back(pinned(CMD_FIND, 32'hFFFF_0000, chks_pkg::ST_FOUND,    4, 6));
    dir_rows.push_back(pinned(CMD_FIND, 32'h8000_0000, chks_pkg::ST_MISSING,  0, 6));
    dir_rows.push_back(pinned(chks_pkg::CMD_ADD, 32'h7FFF_FFFF, chks_pkg::ST_INSERTED, 6, 7));
    dir_rows.push_back(pinned(CMD_FIND, 32'h0001_0001, chks_pkg::ST_FOUND,    3, 7));
    dir_rows.push_back(pinned(chks_pkg::CMD_ADD, 32'h0000_0080, chks_pkg::ST_FOUND,    2, 7));
    dir_rows.push_back(loose(CMD_FIND, r1));
    dir_rows.push_back(loose(chks_pkg::CMD_ADD, r1));
    dir_rows.push_back(loose(CMD_FIND, r1));
    dir_rows.push_back(loose(chks_pkg::CMD_ADD, r2));
    dir_rows.push_back(loose(chks_pkg::CMD_ADD, 32'h5A5A_A5A5));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      typed_results.push_back('{on: dir_rows[i].pin, res: dir_rows[i].res});
      issue(dir_rows[i].req, 32);
    end

    // Sender idles often, table fills
    repeat (300) issue(random_request(50), 32);
    drain_results();

    repeat (300) issue(random_request(50), 50);
    drain_results();

    // Fill any remaining slots with fresh keys so the full case is reached
    top_up = TableSize - n_keys;
    repeat (top_up) begin
      do begin
        fresh = $urandom;
        clash = locate_key(fresh, pos);
        foreach (chosen[j]) if (chosen[j] == fresh) clash = 1'b1;
      end while (clash);
      chosen.push_back(fresh);
      issue('{cmd: chks_pkg::CMD_ADD, key: fresh}, 0);
    end

    // Full table, back-to-back transfers
    repeat (250) issue(random_request(50), 0);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Ran %0d transfers: %0d found, %0d inserted, %0d missing, %0d full",
             transfers, seen_status[chks_pkg::ST_FOUND], seen_status[chks_pkg::ST_INSERTED],
             seen_status[chks_pkg::ST_MISSING], seen_status[chks_pkg::ST_FULL]);
    $display("Keys stored at end: %0d of %0d, in %0d cycles", n_keys, TableSize, cycles);
    if (errors == 0 && owed_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
